// File: rtl/core/tep_pkg.sv
// Package for the timed entry playback core: widths, codes, microcode table.
`default_nettype none
package tep_pkg;

    localparam int DEPTH     = 256;
    localparam int MAX_EMITS = 16;

    localparam int IDX_W    = $clog2(DEPTH);
    localparam int SLOT_W   = IDX_W + 1;
    localparam int ECNT_W   = 9;
    localparam int TIME_W   = 40;
    localparam int NOW_W    = 48;
    localparam int PAY_W    = 64;
    localparam int SCALE_W  = 16;
    localparam int CNT_W    = $clog2(MAX_EMITS + 1);
    localparam int PROD_W   = NOW_W + SCALE_W;
    localparam int FUNC_W   = 2;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int S_IDX_LSB  = 0;
    localparam int S_TIME_LSB = S_IDX_LSB + IDX_W;
    localparam int S_PAY_LSB  = S_TIME_LSB + TIME_W;
    localparam int S_NOW_LSB  = S_PAY_LSB + PAY_W;
    localparam int S_FIELD_W  = S_NOW_LSB + NOW_W;
    localparam int S_TDATA_W  = ((S_FIELD_W + 7) / 8) * 8;
    localparam int M_FIELD_W  = IDX_W + PAY_W + CNT_W;
    localparam int M_TDATA_W  = ((M_FIELD_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELD_W;

    localparam logic [CFG_IDX_W-1:0] CFG_TIME_SCALE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOPING     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd2;
    localparam logic [SCALE_W-1:0]   SCALE_RESET     = 16'd256;

    typedef enum logic [FUNC_W-1:0] {
        FN_LOAD  = 2'd0,
        FN_START = 2'd1,
        FN_STOP  = 2'd2,
        FN_POLL  = 2'd3
    } func_t;

    typedef enum logic [KIND_W-1:0] {
        KD_ENTRY   = 2'd0,
        KD_STARTED = 2'd1,
        KD_REFUSED = 2'd2,
        KD_DONE    = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        UP_FETCH     = 4'd0,
        UP_LOAD      = 4'd1,
        UP_STOP      = 4'd2,
        UP_START     = 4'd3,
        UP_START_RUN = 4'd4,
        UP_START_GO  = 4'd5,
        UP_POLL      = 4'd6,
        UP_SCALE     = 4'd7,
        UP_SPAN      = 4'd8,
        UP_LOOP      = 4'd9,
        UP_WRAPCHK   = 4'd10,
        UP_TEST      = 4'd11,
        UP_EMIT      = 4'd12,
        UP_DONE      = 4'd13,
        UP_REFUSE    = 4'd14
    } upc_t;

    typedef enum logic [2:0] {
        FL_TRUE    = 3'd0,
        FL_EMPTY   = 3'd1,
        FL_RUNNING = 3'd2,
        FL_IDLE    = 3'd3,
        FL_LIMIT   = 3'd4,
        FL_END     = 3'd5,
        FL_LATE    = 3'd6
    } flag_sel_t;

    typedef struct packed {
        logic      fetch;
        logic      mem_we;
        logic      stop;
        logic      arm;
        logic      calc_elapsed;
        logic      rd_first;
        logic      calc_prod;
        logic      calc_span;
        logic      wrap_or_read;
        logic      emit_entry;
        logic      emit_done;
        logic      emit_refuse;
        flag_sel_t flag;
        upc_t      tgt_t;
        upc_t      tgt_f;
    } ctl_word_t;

    typedef struct packed {
        logic empty;
        logic running;
        logic idle;
        logic limit;
        logic at_end;
        logic late;
        logic out_free;
    } flags_t;

    function automatic upc_t dispatch(func_t f);
        upc_t u;
        unique case (f)
            FN_LOAD:  u = UP_LOAD;
            FN_START: u = UP_START;
            FN_STOP:  u = UP_STOP;
            FN_POLL:  u = UP_POLL;
            default:  u = UP_FETCH;
        endcase
        return u;
    endfunction

    function automatic ctl_word_t ucode(upc_t pc);
        ctl_word_t w;
        w = '0;
        w.flag  = FL_TRUE;
        w.tgt_t = UP_FETCH;
        w.tgt_f = UP_FETCH;
        unique case (pc)
            UP_FETCH:     w.fetch = 1'b1;
            UP_LOAD:      w.mem_we = 1'b1;
            UP_STOP:      w.stop = 1'b1;
            UP_START: begin
                w.flag  = FL_EMPTY;
                w.tgt_t = UP_REFUSE;
                w.tgt_f = UP_START_RUN;
            end
            UP_START_RUN: begin
                w.flag  = FL_RUNNING;
                w.tgt_t = UP_DONE;
                w.tgt_f = UP_START_GO;
            end
            UP_START_GO: begin
                w.arm   = 1'b1;
                w.tgt_t = UP_POLL;
            end
            UP_POLL: begin
                w.calc_elapsed = 1'b1;
                w.rd_first     = 1'b1;
                w.flag         = FL_IDLE;
                w.tgt_t        = UP_DONE;
                w.tgt_f        = UP_SCALE;
            end
            UP_SCALE: begin
                w.calc_prod = 1'b1;
                w.tgt_t     = UP_SPAN;
            end
            UP_SPAN: begin
                w.calc_span = 1'b1;
                w.tgt_t     = UP_LOOP;
            end
            UP_LOOP: begin
                w.flag  = FL_LIMIT;
                w.tgt_t = UP_DONE;
                w.tgt_f = UP_WRAPCHK;
            end
            UP_WRAPCHK: begin
                w.wrap_or_read = 1'b1;
                w.flag         = FL_END;
                w.tgt_t        = UP_LOOP;
                w.tgt_f        = UP_TEST;
            end
            UP_TEST: begin
                w.flag  = FL_LATE;
                w.tgt_t = UP_DONE;
                w.tgt_f = UP_EMIT;
            end
            UP_EMIT: begin
                w.emit_entry = 1'b1;
                w.tgt_t      = UP_LOOP;
            end
            UP_DONE:      w.emit_done = 1'b1;
            UP_REFUSE:    w.emit_refuse = 1'b1;
            default:      w.tgt_t = UP_FETCH;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/tep_sequencer.sv
// Microcode step counter: fetches control words and resolves branches.
`default_nettype none
module tep_sequencer (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    input  wire logic [tep_pkg::FUNC_W-1:0] s_tuser,
    input  wire tep_pkg::flags_t          flags,
    output tep_pkg::ctl_word_t            ctl,
    output logic                          s_tready
);
    import tep_pkg::*;

    upc_t      upc_reg;
    upc_t      upc_next;
    ctl_word_t cw;
    logic      emit;
    logic      stall;
    logic      flag_val;

    assign cw    = ucode(upc_reg);
    assign emit  = cw.emit_entry | cw.emit_done | cw.emit_refuse;
    assign stall = emit & ~flags.out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= UP_FETCH;
        end else begin
            upc_reg <= upc_next;
        end
    end

    always_comb begin
        unique case (cw.flag)
            FL_TRUE:    flag_val = 1'b1;
            FL_EMPTY:   flag_val = flags.empty;
            FL_RUNNING: flag_val = flags.running;
            FL_IDLE:    flag_val = flags.idle;
            FL_LIMIT:   flag_val = flags.limit;
            FL_END:     flag_val = flags.at_end;
            FL_LATE:    flag_val = flags.late;
            default:    flag_val = 1'b1;
        endcase

        priority if (cw.fetch) begin
            upc_next = s_tvalid ? dispatch(func_t'(s_tuser)) : UP_FETCH;
        end else if (stall) begin
            upc_next = upc_reg;
        end else begin
            upc_next = flag_val ? cw.tgt_t : cw.tgt_f;
        end

        ctl = stall ? ctl_word_t'('0) : cw;
    end

    assign s_tready = cw.fetch;

endmodule
`default_nettype wire

// File: rtl/core/tep_datapath.sv
// Datapath: entry table, timing registers, config registers, result register.
`default_nettype none
module tep_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire tep_pkg::ctl_word_t            ctl,
    output tep_pkg::flags_t                    flags,
    input  wire logic                          s_tvalid,
    input  wire logic [tep_pkg::FUNC_W-1:0]    s_tuser,
    input  wire logic [tep_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [tep_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tep_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [tep_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [tep_pkg::KIND_W-1:0]         m_tuser,
    output logic                               m_tlast
);
    import tep_pkg::*;

    logic [TIME_W-1:0] due_mem [DEPTH];
    logic [PAY_W-1:0]  pay_mem [DEPTH];

    logic [IDX_W-1:0]   idx_reg;
    logic [TIME_W-1:0]  time_reg;
    logic [PAY_W-1:0]   payload_reg;
    logic [NOW_W-1:0]   now_reg;
    logic               start_mode_reg;

    logic [SCALE_W-1:0] scale_reg;
    logic               looping_reg;
    logic [ECNT_W-1:0]  entry_count_reg;

    logic               running_reg;
    logic [SLOT_W-1:0]  next_slot_reg;
    logic [NOW_W-1:0]   origin_reg;
    logic [NOW_W-1:0]   lap_reg;
    logic [CNT_W-1:0]   count_reg;

    logic [NOW_W-1:0]   elapsed_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [NOW_W-1:0]   scaled_reg;
    logic [TIME_W-1:0]  first_reg;
    logic [TIME_W-1:0]  span_reg;
    logic [NOW_W-1:0]   script_reg;
    logic [TIME_W-1:0]  due_rd_reg;
    logic [PAY_W-1:0]   pay_rd_reg;

    logic               out_valid_reg;
    kind_t              out_kind_reg;
    logic [IDX_W-1:0]   out_idx_reg;
    logic [PAY_W-1:0]   out_pay_reg;
    logic [CNT_W-1:0]   out_cnt_reg;
    logic               out_last_reg;

    logic               accept;
    logic [SLOT_W-1:0]  used;
    logic               at_end;
    logic               out_free;
    logic               rd_en;
    logic [IDX_W-1:0]   raddr;
    logic [TIME_W-1:0]  due_rel;
    logic [NOW_W:0]     lap_sum;
    logic               emit_any;

    assign accept   = ctl.fetch & s_tvalid;
    assign used     = (SLOT_W'(entry_count_reg) > SLOT_W'(DEPTH)) ? SLOT_W'(DEPTH)
                                                                  : SLOT_W'(entry_count_reg);
    assign at_end   = next_slot_reg >= used;
    assign out_free = ~out_valid_reg | m_tready;
    assign due_rel  = (due_rd_reg > first_reg) ? due_rd_reg - first_reg : '0;
    assign lap_sum  = {1'b0, lap_reg} + (NOW_W + 1)'(span_reg);
    assign emit_any = ctl.emit_entry | ctl.emit_done | ctl.emit_refuse;

    always_comb begin
        flags.empty    = (used == '0);
        flags.running  = running_reg;
        flags.idle     = ~running_reg | (used == '0);
        flags.limit    = (count_reg == CNT_W'(MAX_EMITS)) ||
                         (at_end && (!looping_reg || span_reg == '0));
        flags.at_end   = at_end;
        flags.late     = script_reg < NOW_W'(due_rel);
        flags.out_free = out_free;
    end

    always_comb begin
        rd_en = 1'b0;
        raddr = '0;
        if (ctl.rd_first) begin
            rd_en = 1'b1;
        end else if (ctl.calc_prod) begin
            rd_en = 1'b1;
            raddr = IDX_W'(used - SLOT_W'(1));
        end else if (ctl.wrap_or_read && !at_end) begin
            rd_en = 1'b1;
            raddr = next_slot_reg[IDX_W-1:0];
        end
    end

    // table memories
    always_ff @(posedge aclk) begin
        if (ctl.mem_we) begin
            due_mem[idx_reg] <= time_reg;
            pay_mem[idx_reg] <= payload_reg;
        end
        if (rd_en) begin
            due_rd_reg <= due_mem[raddr];
            pay_rd_reg <= pay_mem[raddr];
        end
    end

    // latched item and timing payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            idx_reg        <= s_tdata[S_IDX_LSB +: IDX_W];
            time_reg       <= s_tdata[S_TIME_LSB +: TIME_W];
            payload_reg    <= s_tdata[S_PAY_LSB +: PAY_W];
            now_reg        <= s_tdata[S_NOW_LSB +: NOW_W];
            start_mode_reg <= (func_t'(s_tuser) == FN_START);
        end
        if (ctl.calc_elapsed) begin
            elapsed_reg <= (now_reg >= origin_reg) ? now_reg - origin_reg : '0;
        end
        if (ctl.calc_prod) begin
            prod_reg  <= elapsed_reg * scale_reg;
            first_reg <= due_rd_reg;
        end
        if (ctl.calc_span) begin
            scaled_reg <= (|prod_reg[PROD_W-1:NOW_W+8]) ? '1 : prod_reg[NOW_W+7:8];
            span_reg   <= (used > SLOT_W'(1) && due_rd_reg > first_reg)
                          ? due_rd_reg - first_reg : '0;
        end
        if (ctl.wrap_or_read && !at_end) begin
            script_reg <= (scaled_reg > lap_reg) ? scaled_reg - lap_reg : '0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg       <= SCALE_RESET;
            looping_reg     <= 1'b0;
            entry_count_reg <= '0;
            running_reg     <= 1'b0;
            next_slot_reg   <= '0;
            origin_reg      <= '0;
            lap_reg         <= '0;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == CFG_TIME_SCALE && cfg_data != '0) begin
                    scale_reg <= cfg_data;
                end
                if (cfg_index == CFG_LOOPING) begin
                    looping_reg <= cfg_data[0];
                end
                if (cfg_index == CFG_ENTRY_COUNT) begin
                    entry_count_reg <= cfg_data[ECNT_W-1:0];
                end
            end
            if (accept) begin
                count_reg <= '0;
            end
            if (ctl.stop) begin
                running_reg   <= 1'b0;
                next_slot_reg <= '0;
            end
            if (ctl.arm) begin
                origin_reg    <= now_reg;
                lap_reg       <= '0;
                next_slot_reg <= '0;
                running_reg   <= 1'b1;
            end
            if (ctl.wrap_or_read && at_end) begin
                lap_reg       <= lap_sum[NOW_W] ? '1 : lap_sum[NOW_W-1:0];
                next_slot_reg <= '0;
            end
            if (ctl.emit_entry) begin
                next_slot_reg <= next_slot_reg + SLOT_W'(1);
                count_reg     <= count_reg + CNT_W'(1);
            end
            if (emit_any) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (ctl.emit_entry) begin
            out_kind_reg <= KD_ENTRY;
            out_idx_reg  <= next_slot_reg[IDX_W-1:0];
            out_pay_reg  <= pay_rd_reg;
            out_cnt_reg  <= '0;
            out_last_reg <= 1'b0;
        end else if (ctl.emit_done) begin
            out_kind_reg <= start_mode_reg ? KD_STARTED : KD_DONE;
            out_idx_reg  <= '0;
            out_pay_reg  <= '0;
            out_cnt_reg  <= count_reg;
            out_last_reg <= 1'b1;
        end else if (ctl.emit_refuse) begin
            out_kind_reg <= KD_REFUSED;
            out_idx_reg  <= '0;
            out_pay_reg  <= '0;
            out_cnt_reg  <= '0;
            out_last_reg <= 1'b1;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_kind_reg;
    assign m_tlast   = out_last_reg;
    assign m_tdata   = {{M_PAD_W{1'b0}}, out_cnt_reg, out_pay_reg, out_idx_reg};

    a_emit_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_any |-> out_free)
        else $error("result register overwritten");

    a_entry_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.emit_entry |-> (running_reg && !at_end))
        else $error("entry emitted while stopped or past table end");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_EMITS))
        else $error("emit count above limit");

    a_wrap_resets_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.wrap_or_read && at_end) |=> (next_slot_reg == '0))
        else $error("wrap did not restart table");

endmodule
`default_nettype wire

// File: rtl/core/timed_entry_playback_core.sv
// Top level of the timed entry playback core.
// A start on a stopped, non-empty table arms the timer and then polls; a poll
// walks the table, wrapping when looping, through loop, wrap check, test and emit
// steps for each entry. The microcode walk uses one table read port.
// Results wait in one output register; a stalled result holds the sequencer.
// aresetn is synchronous, active low; table contents are undefined until loaded.
`default_nettype none
module timed_entry_playback_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [7:0] entry_index, [47:8] entry_time, [111:48] entry_payload,
    // [159:112] now_time
    input  wire logic [tep_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] func
    input  wire logic [tep_pkg::FUNC_W-1:0]     s_tuser,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tep_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tep_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [7:0] out_index, [71:8] out_payload, [76:72] emitted_count, [79:77] zero
    output logic [tep_pkg::M_TDATA_W-1:0]       m_tdata,
    // [1:0] kind
    output logic [tep_pkg::KIND_W-1:0]          m_tuser,
    output logic                                m_tlast
);
    import tep_pkg::*;

    ctl_word_t ctl;
    flags_t    flags;

    tep_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .flags    (flags),
        .ctl      (ctl),
        .s_tready (s_tready)
    );

    tep_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .flags     (flags),
        .s_tvalid  (s_tvalid),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire

// File: tb/sv/tb_timed_entry_playback_core.sv
// Self-checking testbench for timed_entry_playback_core: stream driver, monitor, predictor.
module tb_timed_entry_playback_core;
    timeunit 1ns;
    timeprecision 1ps;
    import tep_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 480;
    localparam int HOLD_CYCLES  = 400;
    localparam int CALM_FROM    = 3000;
    localparam int CALM_TO      = 6000;
    localparam int SETTLE       = 24;
    localparam int ERR_PRINTS   = 40;

    localparam logic [63:0]       SAT48    = 64'hFFFF_FFFF_FFFF;
    localparam logic [NOW_W-1:0]  NOW_MAX  = '1;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef struct {
        func_t              fn;
        logic [IDX_W-1:0]   slot;
        logic [TIME_W-1:0]  due;
        logic [PAY_W-1:0]   word;
        logic [NOW_W-1:0]   now;
    } cmd_t;

    typedef struct {
        kind_t              kind;
        logic [IDX_W-1:0]   slot;
        logic [PAY_W-1:0]   word;
        logic [CNT_W-1:0]   cnt;
        logic               last;
    } res_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    wire                    s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [FUNC_W-1:0]      s_tuser = '0;
    logic                   cfg_valid = 1'b0;
    wire                    cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    wire                    m_tvalid;
    logic                   m_tready = 1'b0;
    wire  [M_TDATA_W-1:0]   m_tdata;
    wire  [KIND_W-1:0]      m_tuser;
    wire                    m_tlast;

    timed_entry_playback_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #10 aclk = ~aclk;

    // stimulus and scoreboard bookkeeping
    cmd_t   cmd_queue[$];
    res_t   sched_results[$];
    cmd_t   cur_cmd;
    res_t   want;
    int     cyc = 0;
    int     n_gen = 0;
    int     n_acc = 0;
    int     n_acc_seen = 0;
    int     n_checked = 0;
    int     n_err = 0;
    int     kinds_seen[4] = '{0, 0, 0, 0};
    int     hold_asked = 0;
    int     hold_given = 0;
    int     stall_left = 0;
    logic   calm;

    assign calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

    // playback state mirror
    logic [TIME_W-1:0]   p_due  [DEPTH];
    logic [PAY_W-1:0]    p_word [DEPTH];
    logic [SLOT_W-1:0]   p_next = '0;
    logic [NOW_W-1:0]    p_origin = '0;
    logic [NOW_W-1:0]    p_lap = '0;
    logic                p_run = 1'b0;
    logic [SCALE_W-1:0]  p_scale = SCALE_RESET;
    logic                p_loop = 1'b0;
    logic [ECNT_W-1:0]   p_count = '0;
    int                  n_wraps = 0;
    int                  n_capped = 0;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic flag_error(input string msg);
        n_err++;
        if (n_err <= ERR_PRINTS)
            $display("ERROR cycle %0d: %s", cyc, msg);
    endtask

    task automatic push_result(input kind_t k, input logic [IDX_W-1:0] s,
                               input logic [PAY_W-1:0] w, input logic [CNT_W-1:0] c,
                               input logic l);
        res_t r;
        r.kind = k;
        r.slot = s;
        r.word = w;
        r.cnt  = c;
        r.last = l;
        sched_results.insert(sched_results.size(), r);
    endtask

    // walks the table from p_next, emitting every due entry, at most MAX_EMITS
    task automatic walk_table(input logic [NOW_W-1:0] now, output int emitted);
        int n;
        int guard;
        logic walking;
        logic [63:0] elapsed, scaled, first, span, script, due, lapsum;
        emitted = 0;
        n = (p_count > DEPTH) ? DEPTH : int'(p_count);
        if (p_run && n != 0) begin
            elapsed = (now >= p_origin) ? 64'(now - p_origin) : 64'd0;
            scaled = (elapsed * p_scale) >> 8;
            if (scaled > SAT48)
                scaled = SAT48;
            first = p_due[0];
            span = 0;
            if (n >= 2 && p_due[n-1] > first)
                span = p_due[n-1] - first;
            walking = 1'b1;
            guard = 0;
            while (walking && guard < 2 * MAX_EMITS + 4 && emitted < MAX_EMITS) begin
                guard++;
                if (p_next >= n) begin
                    if (!p_loop || span == 0) begin
                        walking = 1'b0;
                    end else begin
                        lapsum = p_lap + span;
                        p_lap = (lapsum > SAT48) ? NOW_MAX : lapsum[NOW_W-1:0];
                        p_next = '0;
                        n_wraps++;
                    end
                end else begin
                    script = (scaled > p_lap) ? scaled - p_lap : 64'd0;
                    due = (p_due[p_next] > first) ? p_due[p_next] - first : 64'd0;
                    if (script < due) begin
                        walking = 1'b0;
                    end else begin
                        push_result(KD_ENTRY, p_next[IDX_W-1:0], p_word[p_next], '0, 1'b0);
                        p_next = p_next + 1'b1;
                        emitted++;
                    end
                end
            end
            if (emitted == MAX_EMITS)
                n_capped++;
        end
    endtask

    task automatic advance_playback(input cmd_t c);
        int k;
        case (c.fn)
            FN_LOAD: begin
                p_due[c.slot]  = c.due;
                p_word[c.slot] = c.word;
            end
            FN_START: begin
                if (p_count == 0) begin
                    push_result(KD_REFUSED, '0, '0, '0, 1'b1);
                end else if (p_run) begin
                    push_result(KD_STARTED, '0, '0, '0, 1'b1);
                end else begin
                    p_origin = c.now;
                    p_lap = '0;
                    p_next = '0;
                    p_run = 1'b1;
                    walk_table(c.now, k);
                    push_result(KD_STARTED, '0, '0, CNT_W'(k), 1'b1);
                end
            end
            FN_STOP: begin
                p_run = 1'b0;
                p_next = '0;
            end
            default: begin
                walk_table(c.now, k);
                push_result(KD_DONE, '0, '0, CNT_W'(k), 1'b1);
            end
        endcase
    endtask

    // accepted transfers update the mirror
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TIME_SCALE:  if (cfg_data != 0) p_scale = cfg_data;
                    CFG_LOOPING:     p_loop = cfg_data[0];
                    CFG_ENTRY_COUNT: p_count = cfg_data[ECNT_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                advance_playback(cur_cmd);
                n_acc++;
            end
        end
    end

    // input driver
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || n_acc != n_acc_seen)) begin
            n_acc_seen = n_acc;
            if (cmd_queue.size() != 0 && (calm || $urandom_range(99) >= 6)) begin
                cur_cmd = cmd_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {cur_cmd.now, cur_cmd.word, cur_cmd.due, cur_cmd.slot};
                s_tuser  <= cur_cmd.fn;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result ready, with one long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (hold_given != hold_asked) begin
            hold_given++;
            stall_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 6);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (sched_results.size() == 0) begin
                flag_error($sformatf("result kind %0d with nothing outstanding", m_tuser));
            end else begin
                want = sched_results.pop_front();
                n_checked++;
                kinds_seen[int'(want.kind)]++;
                if (m_tuser !== want.kind)
                    flag_error($sformatf("kind %0d, expected %0d", m_tuser, want.kind));
                if (m_tdata[IDX_W-1:0] !== want.slot)
                    flag_error($sformatf("index %0d, expected %0d",
                                         m_tdata[IDX_W-1:0], want.slot));
                if (m_tdata[IDX_W+PAY_W-1:IDX_W] !== want.word)
                    flag_error($sformatf("payload %h, expected %h",
                                         m_tdata[IDX_W+PAY_W-1:IDX_W], want.word));
                if (m_tdata[IDX_W+PAY_W+CNT_W-1:IDX_W+PAY_W] !== want.cnt)
                    flag_error($sformatf("count %0d, expected %0d",
                                         m_tdata[IDX_W+PAY_W+CNT_W-1:IDX_W+PAY_W], want.cnt));
                if (m_tlast !== want.last)
                    flag_error($sformatf("tlast %b, expected %b", m_tlast, want.last));
            end
        end
    end

    always @(posedge aclk) begin
        cyc++;
        if (cyc >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cyc, sched_results.size());
            $display("tb_timed_entry_playback_core failed");
            $finish;
        end
    end

    task automatic queue_cmd(input func_t fn, input logic [IDX_W-1:0] s,
                             input logic [TIME_W-1:0] t, input logic [PAY_W-1:0] w,
                             input logic [NOW_W-1:0] now);
        cmd_t c;
        c.fn   = fn;
        c.slot = s;
        c.due  = t;
        c.word = w;
        c.now  = now;
        cmd_queue.insert(cmd_queue.size(), c);
        n_gen++;
    endtask

    task automatic put_load(input logic [IDX_W-1:0] s, input logic [TIME_W-1:0] t,
                            input logic [PAY_W-1:0] w);
        logic [63:0] r;
        r = rand64();
        queue_cmd(FN_LOAD, s, t, w, r[NOW_W-1:0]);
    endtask

    task automatic put_ctrl(input func_t fn, input logic [NOW_W-1:0] now);
        logic [63:0] r;
        r = rand64();
        queue_cmd(fn, r[IDX_W-1:0], r[IDX_W+TIME_W-1:IDX_W], rand64(), now);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // upper data bits are don't-care for the narrow registers
    task automatic set_regs(input logic [SCALE_W-1:0] scale, input logic loop_on,
                            input logic [ECNT_W-1:0] count);
        logic [CFG_DATA_W-1:0] d;
        write_reg(CFG_TIME_SCALE, scale);
        if ($urandom_range(7) == 0)
            write_reg(CFG_TIME_SCALE, '0);
        d = CFG_DATA_W'($urandom);
        d[0] = loop_on;
        write_reg(CFG_LOOPING, d);
        d = CFG_DATA_W'($urandom);
        d[ECNT_W-1:0] = count;
        write_reg(CFG_ENTRY_COUNT, d);
    endtask

    task automatic wait_idle();
        do @(negedge aclk); while (n_acc != n_gen || sched_results.size() != 0);
        repeat (SETTLE) @(negedge aclk);
    endtask

    function automatic logic [SCALE_W-1:0] pick_scale();
        int m;
        m = $urandom_range(99);
        if (m < 40)
            return SCALE_RESET;
        if (m < 55)
            return 16'd1;
        if (m < 70)
            return 16'hFFFF;
        return SCALE_W'($urandom_range(1, 65535));
    endfunction

    // mostly ascending due times, with an occasional entry earlier than the first
    task automatic fill_table(input int n);
        logic [TIME_W-1:0] t0, t;
        logic [63:0] r;
        int m;
        m = $urandom_range(2);
        r = rand64();
        if (m == 0)
            t0 = TIME_W'($urandom_range(0, 5000));
        else if (m == 1)
            t0 = r[TIME_W-1:0];
        else
            t0 = TIME_MAX - TIME_W'($urandom_range(0, 20000));
        t = t0;
        for (int i = 0; i < n; i++) begin
            if (i > 0) begin
                if ($urandom_range(9) == 0)
                    t = (t0 > 1000) ? t0 - TIME_W'($urandom_range(1, 1000)) : '0;
                else
                    t = t + TIME_W'($urandom_range(0, 2500));
            end
            put_load(IDX_W'(i), t, rand64());
        end
    endtask

    // start, then polls on an advancing clock mixed with restarts, reloads and noise
    task automatic run_session(input int steps);
        logic [NOW_W-1:0] now;
        logic [63:0] r;
        int m;
        r = rand64();
        now = ($urandom_range(3) == 0) ? r[NOW_W-1:0] : {1'b0, r[NOW_W-2:0]};
        put_ctrl(FN_START, now);
        repeat (steps) begin
            m = $urandom_range(99);
            r = rand64();
            if (m < 62) begin
                m = $urandom_range(99);
                if (m < 60)
                    now = now + NOW_W'($urandom_range(0, 4000));
                else if (m < 85)
                    now = now + NOW_W'($urandom_range(0, 60000));
                else if (m < 93)
                    now = now + r[NOW_W-1:0];
                else
                    now = now - NOW_W'($urandom_range(0, 5000));
                put_ctrl(FN_POLL, now);
            end else if (m < 70) begin
                put_ctrl(FN_STOP, r[NOW_W-1:0]);
                now = now + NOW_W'($urandom_range(0, 3000));
                put_ctrl(FN_START, now);
            end else if (m < 75) begin
                put_ctrl(FN_START, now);
            end else if (m < 83) begin
                put_load(r[IDX_W-1:0], r[IDX_W+TIME_W-1:IDX_W], rand64());
            end else if (m < 90) begin
                put_ctrl(FN_STOP, r[NOW_W-1:0]);
                put_ctrl(FN_POLL, now);
                put_ctrl(FN_START, now);
            end else begin
                put_ctrl(func_t'($urandom_range(3)), r[NOW_W-1:0]);
            end
        end
    endtask

    initial begin
        int rand_goal;
        int count;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // empty table and stopped poll, then loads for a four-entry table and the last slot
        put_ctrl(FN_START, '0);
        put_ctrl(FN_POLL, '0);
        put_ctrl(FN_STOP, NOW_MAX);
        put_load(8'd0, 40'd1000, '1);
        put_load(8'd1, 40'd500, '0);
        put_load(8'd2, 40'd3000, rand64());
        put_load(8'd3, 40'd5000, 64'hAAAA_AAAA_5555_5555);
        put_load(8'hFF, TIME_MAX, '1);
        wait_idle();

        // looping: restart while running, clock behind origin, wrap, emit cap
        write_reg(CFG_ENTRY_COUNT, 16'd4);
        write_reg(CFG_LOOPING, 16'd1);
        put_ctrl(FN_START, 48'd100);
        put_ctrl(FN_START, 48'd100);
        put_ctrl(FN_POLL, 48'd50);
        put_ctrl(FN_POLL, 48'd5100);
        put_ctrl(FN_POLL, NOW_MAX);
        put_ctrl(FN_POLL, NOW_MAX);
        put_ctrl(FN_STOP, '0);
        put_ctrl(FN_POLL, NOW_MAX);
        wait_idle();

        // max scale saturates the product; zero scale write is dropped
        write_reg(CFG_TIME_SCALE, 16'hFFFF);
        write_reg(CFG_TIME_SCALE, 16'd0);
        write_reg(CFG_LOOPING, 16'd0);
        put_ctrl(FN_START, '0);
        put_ctrl(FN_POLL, NOW_MAX);
        put_ctrl(FN_POLL, NOW_MAX);
        put_ctrl(FN_STOP, '0);
        wait_idle();

        // last entry earlier than the first: zero span, no wrap; left running
        write_reg(CFG_ENTRY_COUNT, 16'd3);
        write_reg(CFG_LOOPING, 16'd1);
        put_load(8'd2, 40'd10, rand64());
        put_ctrl(FN_START, '0);
        put_ctrl(FN_POLL, NOW_MAX);
        wait_idle();

        rand_goal = n_gen + RANDOM_ITEMS;
        for (int phase = 0; n_gen < rand_goal; phase++) begin
            case (phase)
                0: begin
                    // empty table while still running
                    set_regs(pick_scale(), 1'($urandom_range(1)), '0);
                    run_session(8);
                end
                1: begin
                    case ($urandom_range(2))
                        0:       count = 256;
                        1:       count = 300;
                        default: count = 511;
                    endcase
                    set_regs(pick_scale(), 1'b1, ECNT_W'(count));
                    fill_table(DEPTH);
                    run_session(20);
                end
                2: begin
                    // two entries a full 40-bit span apart drive the lap offset to saturation
                    set_regs(16'hFFFF, 1'b1, 9'd2);
                    put_ctrl(FN_STOP, '0);
                    put_load(8'd0, '0, rand64());
                    put_load(8'd1, TIME_MAX, rand64());
                    put_ctrl(FN_START, '0);
                    repeat (36) put_ctrl(FN_POLL, NOW_MAX);
                end
                default: begin
                    if (phase == 3)
                        hold_asked++;
                    if ($urandom_range(11) == 0)
                        count = 0;
                    else if ($urandom_range(5) == 0)
                        count = $urandom_range(200, 511);
                    else
                        count = $urandom_range(1, 12);
                    set_regs(pick_scale(), 1'($urandom_range(1)), ECNT_W'(count));
                    fill_table((count > 16) ? 16 : count);
                    run_session($urandom_range(6, 16));
                end
            endcase
            wait_idle();
        end

        repeat (40) @(negedge aclk);
        $display("%0d inputs, %0d results: %0d entries, %0d starts, %0d refusals, %0d dones",
                 n_acc, n_checked, kinds_seen[KD_ENTRY], kinds_seen[KD_STARTED],
                 kinds_seen[KD_REFUSED], kinds_seen[KD_DONE]);
        $display("%0d capped walks, %0d table wraps, %0d long hold-offs, %0d mismatches",
                 n_capped, n_wraps, hold_given, n_err);
        if (n_err == 0)
            $display("tb_timed_entry_playback_core passed");
        else
            $display("tb_timed_entry_playback_core failed");
        $finish;
    end

endmodule
